// ===== sv/bcrc32_pkg.sv =====
// ----------------------------------------------------------------------------
// bcrc32_pkg
// Shared constants and the byte fold function for the reflected CRC-32 engine.
// ----------------------------------------------------------------------------
package bcrc32_pkg;

  localparam int unsigned CRC_W    = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hD801_8001;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_START_VALUE = 1'b0,
    REG_NONE        = 1'b1
  } reg_idx_e;

  // one byte folded LSB first, equivalent to the 256-entry reflected table
  function automatic logic [CRC_W-1:0] fold_byte(logic [CRC_W-1:0] crc,
                                                 logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] x;
    x = {{(CRC_W-BYTE_W){1'b0}}, crc[BYTE_W-1:0] ^ b};
    for (int i = 0; i < BYTE_W; i++) begin
      if (x[0]) begin
        x = (x >> 1) ^ CRC_POLY;
      end else begin
        x = x >> 1;
      end
    end
    return (crc >> BYTE_W) ^ x;
  endfunction

endpackage

// ===== sv/bcrc32_apb.sv =====
// ----------------------------------------------------------------------------
// bcrc32_apb
// APB register slave holding the start value.
// ----------------------------------------------------------------------------
module bcrc32_apb (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bcrc32_pkg::APB_AW-1:0]     paddr,
  input  logic [bcrc32_pkg::APB_DW-1:0]     pwdata,
  output logic [bcrc32_pkg::APB_DW-1:0]     prdata,
  output logic                              pready,
  output logic [bcrc32_pkg::CRC_W-1:0]      start_value_o
);

  bcrc32_pkg::reg_idx_e          reg_idx;
  logic [bcrc32_pkg::CRC_W-1:0]  start_value_q;
  logic [bcrc32_pkg::CRC_W-1:0]  start_value_d;
  logic                          wr_en;

  assign reg_idx = bcrc32_pkg::reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    start_value_d = start_value_q;
    if (wr_en && (reg_idx == bcrc32_pkg::REG_START_VALUE)) begin
      start_value_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_value_q <= '0;
    end else begin
      start_value_q <= start_value_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      bcrc32_pkg::REG_START_VALUE: prdata = start_value_q;
      default:                     prdata = '0;
    endcase
  end

  assign start_value_o = start_value_q;

endmodule

// ===== sv/bcrc32_fold.sv =====
// ----------------------------------------------------------------------------
// bcrc32_fold
// Seed select and one-byte reflected CRC update.
// ----------------------------------------------------------------------------
module bcrc32_fold (
  input  logic [bcrc32_pkg::CRC_W-1:0]   crc_i,
  input  logic [bcrc32_pkg::CRC_W-1:0]   start_value_i,
  input  logic                           start_i,
  input  logic [bcrc32_pkg::BYTE_W-1:0]  byte_i,
  output logic [bcrc32_pkg::CRC_W-1:0]   crc_o
);

  logic [bcrc32_pkg::CRC_W-1:0] seed;

  assign seed  = start_i ? start_value_i : crc_i;
  assign crc_o = bcrc32_pkg::fold_byte(seed, byte_i);

endmodule

// ===== sv/bytewise_reflected_crc32.sv =====
// ----------------------------------------------------------------------------
// bytewise_reflected_crc32
// Reflected CRC-32 (poly 0xD8018001), one byte per word, no final XOR.
// ----------------------------------------------------------------------------
// Pipeline: input register -> fold -> result register.
// Throughput: 1 word per cycle unless the output stream stalls (m_axis_tready low).
// The result register doubles as the running CRC.
// Reset: running CRC and start value clear to 0, both stages empty.
// ----------------------------------------------------------------------------
module bytewise_reflected_crc32 (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bcrc32_pkg::APB_AW-1:0]      paddr,
  input  logic [bcrc32_pkg::APB_DW-1:0]      pwdata,
  output logic [bcrc32_pkg::APB_DW-1:0]      prdata,
  output logic                               pready,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bcrc32_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] data_byte
  input  logic                               s_axis_tuser,  // [0] start_req
  input  logic                               s_axis_tlast,
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bcrc32_pkg::CRC_W-1:0]       m_axis_tdata,  // [31:0] crc_value
  output logic                               m_axis_tlast   // final_res
);

  logic [bcrc32_pkg::CRC_W-1:0]  start_value;
  logic [bcrc32_pkg::CRC_W-1:0]  crc_next;

  logic                          in_valid_q, in_valid_d;
  logic [bcrc32_pkg::BYTE_W-1:0] in_byte_q;
  logic                          in_start_q;
  logic                          in_last_q;

  logic                          out_valid_q, out_valid_d;
  logic [bcrc32_pkg::CRC_W-1:0]  out_crc_q, out_crc_d;
  logic                          out_last_q;

  logic                          in_fire;
  logic                          adv;

  bcrc32_apb u_apb (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start_value_o (start_value)
  );

  bcrc32_fold u_fold (
    .crc_i         (out_crc_q),
    .start_value_i (start_value),
    .start_i       (in_start_q),
    .byte_i        (in_byte_q),
    .crc_o         (crc_next)
  );

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_fire || (in_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && !m_axis_tready);
  assign out_crc_d   = adv ? crc_next : out_crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_crc_q   <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      out_crc_q   <= out_crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
      in_last_q  <= s_axis_tlast;
    end
    if (adv) begin
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_crc_q;
  assign m_axis_tlast  = out_last_q;

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_axis_tready && !adv) |=> !out_valid_q)
    else $error("result stage not emptied after drain");

  a_adv_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_valid_q && (out_last_q == $past(in_last_q))))
    else $error("result stage not loaded on advance");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without downstream backpressure");

  a_start_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_start_q) |=>
      (out_crc_q == bcrc32_pkg::fold_byte($past(start_value), $past(in_byte_q))))
    else $error("start word not seeded from start value");

  a_hold_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(out_crc_q))
    else $error("running crc changed without a word");

endmodule
